/* sv/svsa_pkg.sv */
// Shared types and constants for the texture record stack allocator.
// Used by the entry RAM, the end address unit and the top level core.
package svsa_pkg;

   // Table depth and the widths that follow from it
   localparam int MAX_ENTRIES = 256;
   localparam int IDX_W       = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   // Field widths
   localparam int ADDR_W  = 20;   // byte address
   localparam int UNIT_W  = 17;   // start address in 8-byte units
   localparam int BASE_W  = 19;
   localparam int PROD_W  = 17;   // width * height

   // Request actions
   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_FREE = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;

   // One table entry
   typedef struct packed {
      logic [8:0]        width;
      logic [7:0]        height;
      logic [2:0]        shift;
      logic [UNIT_W-1:0] start;
   } entry_type;

endpackage

/* sv/svsa_entry_ram.sv */
// Entry table storage: one write port, one read port, registered read data.
// Depends on svsa_pkg for the entry type and table depth.
module svsa_entry_ram
   import svsa_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [MAX_ENTRIES];
   entry_type rd_data_ff;

   // Write one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one word into the registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/svsa_end_calc.sv */
// End address unit: registers width*height, then rounds the byte size and
// adds it to the start. Depends on svsa_pkg for the entry type.
module svsa_end_calc
   import svsa_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  entry_type         entry,
   output logic [ADDR_W-1:0] end_addr
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [2:0]        shift_ff;
   logic [UNIT_W-1:0] start_ff;
   logic [ADDR_W-1:0] bytes_raw;
   logic [ADDR_W-1:0] bytes_round;

   assign prod_in = PROD_W'(entry.width) * PROD_W'(entry.height);

   // Hold the product and the fields needed next cycle
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff  <= prod_in;
         shift_ff <= entry.shift;
         start_ff <= entry.start;
      end
   end

   // Scale by four, shift by pixel size, round up to 32 bytes
   always_comb begin
      bytes_raw   = {1'b0, prod_ff, 2'b00} >> shift_ff;
      bytes_round = (bytes_raw + ADDR_W'(32'h1f)) & ADDR_W'(32'h7ffe0);
      end_addr    = {start_ff, 3'b000} + bytes_round;
   end

endmodule

/* sv/sprite_vram_stack_allocator_core.sv */
// Texture record stack allocator core: entry table in one RAM plus a count.
// A stored add, or a free that reads back its new last entry, goes from decide
// to the end state (product register, then the end address add) before
// rsp_valid; a refused add or free and free all finish from decide.
// Throughput: one request at a time, busy until the result.
// Reset (synchronous, active high) empties the table and clears the base.
module sprite_vram_stack_allocator_core
   import svsa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request
   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  logic [8:0]          req_pixel_width,
   input  logic [7:0]          req_pixel_height,
   input  logic [2:0]          req_size_shift,
   input  logic [7:0]          req_target_id,
   // result
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [7:0]          rsp_new_id,
   output logic [16:0]         rsp_start_address,
   output logic [15:0]         rsp_size_word,
   output logic signed [8:0]   rsp_last_id,
   output logic [19:0]         rsp_next_free,
   // configuration
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [18:0]         csr_data
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_END    = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [BASE_W-1:0] base_ff;

   logic              act_ff;
   logic [8:0]        width_ff;
   logic [7:0]        height_ff;
   logic [2:0]        shift_ff;
   logic [7:0]        target_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_new_id_ff, rsp_new_id_in;
   logic [UNIT_W-1:0] rsp_start_ff, rsp_start_in;
   logic [15:0]       rsp_size_ff, rsp_size_in;
   logic [8:0]        rsp_last_id_ff;
   logic [ADDR_W-1:0] rsp_next_free_ff;

   logic              accept;
   logic              finish;
   logic [15:0]       rd_idx_wide;
   logic [15:0]       cnt_wide;
   logic [15:0]       last_wide;
   logic [ADDR_W-1:0] base_bytes;
   logic [ADDR_W-1:0] alloc_addr;
   logic              table_full;
   logic              target_beyond;

   logic              ram_we;
   entry_type         ram_wdata;
   entry_type         ram_rdata;
   logic              calc_load;
   entry_type         calc_entry;
   logic [ADDR_W-1:0] calc_end;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;

   // Previous entry for a free is read as the request is taken
   assign rd_idx_wide = {8'd0, req_target_id} - 16'd1;

   assign base_bytes    = {1'b0, base_ff[BASE_W-1:3], 3'b000};
   assign alloc_addr    = (cnt_ff == '0) ? base_bytes : tail_ff;
   assign table_full    = (cnt_ff == CNT_W'(MAX_ENTRIES));
   assign target_beyond = (16'(target_ff) >= 16'(cnt_ff));

   assign ram_wdata.width  = width_ff;
   assign ram_wdata.height = height_ff;
   assign ram_wdata.shift  = shift_ff;
   assign ram_wdata.start  = alloc_addr[ADDR_W-1:3];

   svsa_entry_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (rd_idx_wide[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   svsa_end_calc u_end (
      .clock    (clock),
      .load     (calc_load),
      .entry    (calc_entry),
      .end_addr (calc_end)
   );

   // Sequence one request: decide, then finish the end address if needed
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      tail_in       = tail_ff;
      finish        = 1'b0;
      ram_we        = 1'b0;
      calc_load     = 1'b0;
      calc_entry    = ram_wdata;
      rsp_status_in = rsp_status_ff;
      rsp_new_id_in = rsp_new_id_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_size_in   = rsp_size_ff;
      cnt_wide      = 16'(cnt_ff);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            rsp_status_in = ST_DONE;
            rsp_new_id_in = 8'd0;
            rsp_start_in  = '0;
            rsp_size_in   = 16'd0;
            if (act_ff == ACT_ADD) begin
               if (table_full) begin
                  rsp_status_in = ST_FULL;
                  finish        = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  ram_we        = 1'b1;
                  calc_load     = 1'b1;
                  calc_entry    = ram_wdata;
                  rsp_new_id_in = cnt_wide[7:0];
                  rsp_start_in  = ram_wdata.start;
                  rsp_size_in   = {2'b00, width_ff[8:3], height_ff};
                  cnt_in        = cnt_ff + CNT_W'(1);
                  state_in      = S_END;
               end
            end else begin
               if (target_beyond) begin
                  rsp_status_in = ST_IGNORED;
                  finish        = 1'b1;
                  state_in      = S_IDLE;
               end else if (target_ff == 8'd0) begin
                  cnt_in   = '0;
                  finish   = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  calc_load  = 1'b1;
                  calc_entry = ram_rdata;
                  cnt_in     = CNT_W'(target_ff);
                  state_in   = S_END;
               end
            end
         end
         S_END: begin
            tail_in  = calc_end;
            finish   = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = finish;
      last_wide    = 16'(cnt_in) - 16'd1;
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            base_ff <= csr_data;
         end
      end
   end

   // Hold the request word and the tail address
   always_ff @(posedge clock) begin
      tail_ff <= tail_in;
      if (accept) begin
         act_ff    <= req_action;
         width_ff  <= req_pixel_width;
         height_ff <= req_pixel_height;
         shift_ff  <= req_size_shift;
         target_ff <= req_target_id;
      end
   end

   // Result word registers
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_new_id_ff <= rsp_new_id_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_size_ff   <= rsp_size_in;
      if (finish) begin
         rsp_last_id_ff   <= last_wide[8:0];
         rsp_next_free_ff <= (cnt_in == '0) ? base_bytes : tail_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_new_id        = rsp_new_id_ff;
   assign rsp_start_address = rsp_start_ff;
   assign rsp_size_word     = rsp_size_ff;
   assign rsp_last_id       = $signed(rsp_last_id_ff);
   assign rsp_next_free     = rsp_next_free_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      16'(cnt_ff) <= 16'(MAX_ENTRIES))
      else $error("entry count above table depth");

   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_DECIDE))
      else $error("accepted request did not reach decide");

   a_write_on_add: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_DECIDE && act_ff == ACT_ADD && !table_full))
      else $error("table write outside an add");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DONE) |->
         (rsp_new_id == 8'd0 && rsp_start_address == 17'd0 && rsp_size_word == 16'd0))
      else $error("refused request carries entry data");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results for one request");
`endif

endmodule
